@@ rtl/srq_pkg.sv @@
package srq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int KEY_W = 10;
	localparam int HALF_W = 48;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int OCC_W = 7;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_REMOVED = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [HALF_W-1:0] hi;
		logic [HALF_W-1:0] lo;
	} entry_t;

	typedef struct packed {
		logic ins;
		logic rem;
	} cmd_t;

endpackage

@@ rtl/srq_cell.sv @@
module srq_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  srq_pkg::cmd_t   cmd,
	input  srq_pkg::entry_t new_entry,
	input  logic            prev_ge,
	input  logic            prev_valid,
	input  srq_pkg::entry_t prev_entry,
	input  logic            next_valid,
	input  srq_pkg::entry_t next_entry,
	output logic            ge,
	output logic            valid_q,
	output srq_pkg::entry_t entry_q
);

	assign ge = !valid_q || (new_entry.key <= entry_q.key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.ins) begin
			if (prev_ge) begin
				valid_q <= prev_valid;
			end else if (ge) begin
				valid_q <= 1'b1;
			end
		end else if (cmd.rem) begin
			valid_q <= next_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			// shift down behind the insertion point, take the new entry at it
			if (prev_ge) begin
				entry_q <= prev_entry;
			end else if (ge) begin
				entry_q <= new_entry;
			end
		end else if (cmd.rem) begin
			entry_q <= next_entry;
		end
	end

endmodule

@@ rtl/sorted_reorder_queue.sv @@
// Channel   Handshake              Fields
// request   start / busy           opcode, seq_key, payload_hi, payload_lo
// result    done (one-cycle pulse) status, out_key, out_payload_hi, out_payload_lo, occupancy
//
// One request per cycle; busy stays low. The result appears in the cycle after acceptance.
// Every cell of the sorted chain compares against the new key and shifts in the same cycle.
// Reset (arst_n low) empties the chain and clears the entry count; no clearing pass.
// The receiver cannot stall; each result is shown for exactly one cycle.
module sorted_reorder_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         opcode,
	input  logic [srq_pkg::KEY_W-1:0]    seq_key,
	input  logic [srq_pkg::HALF_W-1:0]   payload_hi,
	input  logic [srq_pkg::HALF_W-1:0]   payload_lo,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [srq_pkg::KEY_W-1:0]    out_key,
	output logic [srq_pkg::HALF_W-1:0]   out_payload_hi,
	output logic [srq_pkg::HALF_W-1:0]   out_payload_lo,
	output logic [srq_pkg::OCC_W-1:0]    occupancy
);

	logic accept;
	logic full;
	logic empty;
	srq_pkg::cmd_t cmd;
	srq_pkg::entry_t new_entry;
	logic [srq_pkg::CNT_W-1:0] count_q;
	logic [srq_pkg::CNT_W-1:0] count_next;
	logic [srq_pkg::QUEUE_DEPTH-1:0] ge_w;
	logic [srq_pkg::QUEUE_DEPTH-1:0] valid_w;
	srq_pkg::entry_t cell_entry [srq_pkg::QUEUE_DEPTH];
	logic done_q;
	logic [1:0] status_q;
	srq_pkg::entry_t out_q;
	logic [srq_pkg::CNT_W-1:0] occ_q;

	assign busy = 1'b0;
	assign accept = start && !busy;
	assign full = (count_q == srq_pkg::CNT_W'(srq_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign new_entry = '{key: seq_key, hi: payload_hi, lo: payload_lo};
	assign cmd.ins = accept && (opcode == srq_pkg::OP_INSERT) && !full;
	assign cmd.rem = accept && (opcode == srq_pkg::OP_REMOVE) && !empty;

	always_comb begin
		count_next = count_q;
		if (cmd.ins) begin
			count_next = count_q + 1'b1;
		end else if (cmd.rem) begin
			count_next = count_q - 1'b1;
		end
	end

	for (genvar i = 0; i < srq_pkg::QUEUE_DEPTH; i++) begin : g_cell
		logic prev_ge;
		logic prev_valid;
		srq_pkg::entry_t prev_entry;
		logic next_valid;
		srq_pkg::entry_t next_entry;

		if (i == 0) begin : g_head
			assign prev_ge = 1'b0;
			assign prev_valid = 1'b0;
			assign prev_entry = new_entry;
		end else begin : g_body
			assign prev_ge = ge_w[i-1];
			assign prev_valid = valid_w[i-1];
			assign prev_entry = cell_entry[i-1];
		end

		if (i == srq_pkg::QUEUE_DEPTH - 1) begin : g_tail
			assign next_valid = 1'b0;
			assign next_entry = new_entry;
		end else begin : g_mid
			assign next_valid = valid_w[i+1];
			assign next_entry = cell_entry[i+1];
		end

		srq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.new_entry  (new_entry),
			.prev_ge    (prev_ge),
			.prev_valid (prev_valid),
			.prev_entry (prev_entry),
			.next_valid (next_valid),
			.next_entry (next_entry),
			.ge         (ge_w[i]),
			.valid_q    (valid_w[i]),
			.entry_q    (cell_entry[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q <= 1'b0;
		end else begin
			count_q <= count_next;
			done_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			occ_q <= count_next;
			if (opcode == srq_pkg::OP_INSERT) begin
				status_q <= full ? srq_pkg::ST_FULL : srq_pkg::ST_INSERTED;
				out_q <= '0;
			end else if (empty) begin
				status_q <= srq_pkg::ST_EMPTY;
				out_q <= '0;
			end else begin
				status_q <= srq_pkg::ST_REMOVED;
				out_q <= cell_entry[0];
			end
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign out_key = out_q.key;
	assign out_payload_hi = out_q.hi;
	assign out_payload_lo = out_q.lo;
	assign occupancy = srq_pkg::OCC_W'(occ_q);

`ifndef SYNTHESIS
	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_w) == int'(count_q))
		else $error("entry count differs from occupied cells");

	a_result_follows_request: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted request gave no result");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		valid_w[1] |-> (cell_entry[0].key <= cell_entry[1].key))
		else $error("head cells out of order");

	a_occupancy_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (occ_q == count_q))
		else $error("reported occupancy differs from count");
`endif

endmodule
